/* hw/rtl/spi_motion_sensor_registers_defines.svh */
// Assertion macros used by the checker file.
`ifndef SPI_MOTION_SENSOR_REGISTERS_DEFINES_SVH
`define SPI_MOTION_SENSOR_REGISTERS_DEFINES_SVH

// same-cycle implication, off while in reset
`define SMSR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while in reset
`define SMSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/smsr_pkg.sv */
// Shared types, constants and sizes of the SPI motion sensor register block.
package smsr_pkg;

	localparam int STORE_DEPTH = 256;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int S_TDATA_W   = 144;
	localparam int S_TUSER_W   = 2;
	localparam int M_TDATA_W   = 8;

	localparam logic [1:0] ACT_CS   = 2'd0;
	localparam logic [1:0] ACT_RISE = 2'd1;
	localparam logic [1:0] ACT_FALL = 2'd2;

	localparam logic [7:0] ADDR_GYRO_CFG  = 8'h1B;
	localparam logic [7:0] ADDR_ACCEL_CFG = 8'h1C;
	localparam logic [7:0] ADDR_POWER     = 8'h6B;
	localparam logic [7:0] ADDR_IDENT     = 8'h75;
	localparam logic [7:0] SAMPLE_FIRST   = 8'h3B;
	localparam logic [7:0] SAMPLE_LAST    = 8'h48;
	localparam logic [7:0] IDENT_VALUE    = 8'h68;
	localparam logic [7:0] POWER_RESET    = 8'h40;

	typedef logic [ADDR_W-1:0] store_idx_t;

	typedef struct packed {
		logic [1:0] action;
		logic       cs_level;
		logic       sdi_bit;
	} pin_t;

	typedef struct packed {
		logic signed [20:0] accel_x;
		logic signed [20:0] accel_y;
		logic signed [20:0] accel_z;
		logic signed [20:0] rate_x;
		logic signed [20:0] rate_y;
		logic signed [20:0] rate_z;
		logic signed [15:0] temp_centi;
	} sensor_t;

	// accel x,y,z, temp, rate x,y,z in register order
	typedef logic [6:0][15:0] sample_set_t;

	typedef struct packed {
		logic [1:0] afs;
		logic [1:0] gfs;
	} fs_t;

	typedef struct packed {
		logic       we;
		logic       clr;
		store_idx_t idx;
		logic [7:0] data;
	} store_wr_t;

endpackage

/* hw/rtl/smsr_scale.sv */
// Input register and two scaling stages that turn raw sensor values into 16-bit samples.
module smsr_scale (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  smsr_pkg::pin_t        in_pin,
	input  smsr_pkg::sensor_t     in_sens,
	input  smsr_pkg::fs_t         fs,
	output logic                  out_valid,
	input  logic                  out_ready,
	output smsr_pkg::pin_t        out_pin,
	output smsr_pkg::sample_set_t out_samp
);

	localparam logic signed [16:0] TEMP_OFFSET = 17'sd3653;
	localparam logic [19:0]        RECIP_10    = 20'd838861;

	logic                  v_s1, v_s2, v_s3;
	logic                  en1, en2, en3;
	smsr_pkg::pin_t        pin_s1, pin_s2, pin_s3;
	smsr_pkg::sensor_t     sens_s1;
	logic signed [20:0]    acc_s2 [3];
	logic signed [28:0]    gyr_s2 [3];
	logic [20:0]           tmp_n_s2;
	logic                  tmp_neg_s2;
	smsr_pkg::sample_set_t samp_s3;
	logic [21:0]           tmp_pre;

	function automatic logic [15:0] sat16(logic neg, logic [29:0] q);
		logic [15:0] r;
		if (neg) begin
			r = (q > 30'd32768) ? 16'h8000 : 16'(30'd0 - q);
		end else begin
			r = (q > 30'd32767) ? 16'h7FFF : q[15:0];
		end
		return r;
	endfunction

	function automatic logic signed [28:0] gyro_mul(logic signed [20:0] r);
		logic signed [29:0] p;
		p = r * 30'sd131;
		return p[28:0];
	endfunction

	function automatic logic [21:0] temp_prep(logic signed [15:0] t);
		logic signed [16:0] d;
		logic [16:0]        mag;
		logic [21:0]        n;
		d   = 17'(t) - TEMP_OFFSET;
		mag = d[16] ? 17'(17'd0 - d) : 17'(d);
		n   = 22'(mag) * 22'd34 + 22'd5;
		return {d[16], n[20:0]};
	endfunction

	function automatic logic [15:0] accel_round(logic signed [20:0] a, logic [1:0] sh);
		logic [20:0] mag;
		logic [21:0] half;
		logic [21:0] q;
		mag  = a[20] ? 21'(21'd0 - a) : 21'(a);
		half = (22'd1 << sh) >> 1;
		q    = (22'(mag) + half) >> sh;
		return sat16(a[20], 30'(q));
	endfunction

	function automatic logic [15:0] gyro_round(logic signed [28:0] p, logic [1:0] gfs);
		logic [28:0] mag;
		logic [4:0]  sh;
		logic [29:0] half;
		logic [29:0] q;
		mag  = p[28] ? 29'(29'd0 - p) : 29'(p);
		sh   = 5'd8 + 5'(gfs);
		half = (30'd1 << sh) >> 1;
		q    = (30'(mag) + half) >> sh;
		return sat16(p[28], q);
	endfunction

	function automatic logic [15:0] temp_round(logic [20:0] n, logic neg);
		logic [40:0] prod;
		prod = 41'(n) * 41'(RECIP_10);
		return sat16(neg, 30'(prod[40:23]));
	endfunction

	assign en3      = !v_s3 || out_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;
	assign tmp_pre  = temp_prep(sens_s1.temp_centi);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			pin_s1  <= in_pin;
			sens_s1 <= in_sens;
		end
		if (en2) begin
			pin_s2     <= pin_s1;
			acc_s2[0]  <= sens_s1.accel_x;
			acc_s2[1]  <= sens_s1.accel_y;
			acc_s2[2]  <= sens_s1.accel_z;
			gyr_s2[0]  <= gyro_mul(sens_s1.rate_x);
			gyr_s2[1]  <= gyro_mul(sens_s1.rate_y);
			gyr_s2[2]  <= gyro_mul(sens_s1.rate_z);
			tmp_neg_s2 <= tmp_pre[21];
			tmp_n_s2   <= tmp_pre[20:0];
		end
		if (en3) begin
			pin_s3     <= pin_s2;
			samp_s3[0] <= accel_round(acc_s2[0], fs.afs);
			samp_s3[1] <= accel_round(acc_s2[1], fs.afs);
			samp_s3[2] <= accel_round(acc_s2[2], fs.afs);
			samp_s3[3] <= temp_round(tmp_n_s2, tmp_neg_s2);
			samp_s3[4] <= gyro_round(gyr_s2[0], fs.gfs);
			samp_s3[5] <= gyro_round(gyr_s2[1], fs.gfs);
			samp_s3[6] <= gyro_round(gyr_s2[2], fs.gfs);
		end
	end

	assign out_valid = v_s3;
	assign out_pin   = pin_s3;
	assign out_samp  = samp_s3;

endmodule

/* hw/rtl/smsr_store.sv */
// Register store: byte memory with per-entry valid bits and shadowed full-scale fields.
module smsr_store (
	input  logic                 clk,
	input  logic                 arst_n,
	input  smsr_pkg::store_wr_t  wr,
	input  smsr_pkg::store_idx_t rd_idx,
	output logic [7:0]           rd_data,
	output smsr_pkg::fs_t        fs
);

	logic [7:0]                      mem [smsr_pkg::STORE_DEPTH];
	logic [7:0]                      rd_q;
	smsr_pkg::store_idx_t            ra_q;
	logic [smsr_pkg::STORE_DEPTH-1:0] valid_q;
	smsr_pkg::fs_t                   fs_q;

	always_ff @(posedge clk) begin
		if (wr.we) mem[wr.idx] <= wr.data;
		rd_q <= (wr.we && (wr.idx == rd_idx)) ? wr.data : mem[rd_idx];
		ra_q <= rd_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fs_q    <= '0;
		end else if (wr.clr) begin
			valid_q <= '0;
			fs_q    <= '0;
		end else if (wr.we) begin
			valid_q[wr.idx] <= 1'b1;
			if (wr.idx == smsr_pkg::ADDR_W'(smsr_pkg::ADDR_ACCEL_CFG)) fs_q.afs <= wr.data[4:3];
			if (wr.idx == smsr_pkg::ADDR_W'(smsr_pkg::ADDR_GYRO_CFG)) fs_q.gfs <= wr.data[4:3];
		end
	end

	// unwritten entries read as their reset value
	assign rd_data = valid_q[ra_q] ? rd_q :
		((ra_q == smsr_pkg::ADDR_W'(smsr_pkg::ADDR_POWER)) ? smsr_pkg::POWER_RESET : 8'h00);
	assign fs      = fs_q;

endmodule

/* hw/rtl/smsr_spi.sv */
// SPI shift state, command decode and result register.
module smsr_spi (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         beat_valid,
	output logic                         beat_ready,
	input  smsr_pkg::pin_t               pin,
	input  smsr_pkg::sample_set_t        samp,
	input  logic [7:0]                   rd_data,
	output smsr_pkg::store_idx_t         rd_idx,
	output smsr_pkg::store_wr_t          wr,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [smsr_pkg::M_TDATA_W-1:0] m_tdata
);

	logic       mval_q;
	logic       sel_q, cmd_q, rmode_q, sdo_q, pend_q;
	logic [7:0] ptr_q, sib_q, so_q;
	logic [3:0] ibc_q, obc_q;
	logic       sel_d, cmd_d, rmode_d, sdo_d, pend_d;
	logic [7:0] ptr_d, sib_d, so_d;
	logic [3:0] ibc_d, obc_d;
	logic       fire;
	logic [7:0] so_cur, byte_in, load_addr;
	logic [3:0] ibc_n, obc_n;
	logic       load_en;
	logic [8:0] load_res;

	function automatic logic in_range(logic [7:0] a);
		return ({1'b0, a} < 9'(smsr_pkg::STORE_DEPTH));
	endfunction

	// returns {from store, byte}
	function automatic logic [8:0] load_value(logic [7:0] a, smsr_pkg::sample_set_t s);
		logic [7:0]  off;
		logic [15:0] v;
		logic [8:0]  r;
		off = a - smsr_pkg::SAMPLE_FIRST;
		case (off[3:1])
			3'd0:    v = s[0];
			3'd1:    v = s[1];
			3'd2:    v = s[2];
			3'd3:    v = s[3];
			3'd4:    v = s[4];
			3'd5:    v = s[5];
			3'd6:    v = s[6];
			default: v = 16'h0000;
		endcase
		if (a >= smsr_pkg::SAMPLE_FIRST && a <= smsr_pkg::SAMPLE_LAST) begin
			r = {1'b0, (off[0] ? v[7:0] : v[15:8])};
		end else if (a == smsr_pkg::ADDR_IDENT) begin
			r = {1'b0, smsr_pkg::IDENT_VALUE};
		end else if (in_range(a)) begin
			r = {1'b1, 8'h00};
		end else begin
			r = 9'h000;
		end
		return r;
	endfunction

	assign beat_ready = !mval_q || m_tready;
	assign fire       = beat_valid && beat_ready;
	assign so_cur     = pend_q ? rd_data : so_q;

	always_comb begin
		sel_d     = sel_q;
		cmd_d     = cmd_q;
		rmode_d   = rmode_q;
		sdo_d     = sdo_q;
		ptr_d     = ptr_q;
		sib_d     = sib_q;
		ibc_d     = ibc_q;
		obc_d     = obc_q;
		so_d      = so_cur;
		pend_d    = 1'b0;
		wr        = '0;
		load_en   = 1'b0;
		load_addr = ptr_q;
		byte_in   = {sib_q[6:0], pin.sdi_bit};
		ibc_n     = ibc_q + 4'd1;
		obc_n     = obc_q + 4'd1;
		if (fire) begin
			case (pin.action)
				smsr_pkg::ACT_CS: begin
					sel_d   = !pin.cs_level;
					cmd_d   = 1'b0;
					rmode_d = 1'b0;
					ptr_d   = 8'h00;
					sib_d   = 8'h00;
					ibc_d   = 4'd0;
					so_d    = 8'hFF;
					obc_d   = 4'd0;
					sdo_d   = 1'b1;
				end
				smsr_pkg::ACT_FALL: begin
					if (sel_q && rmode_q && cmd_q) sdo_d = so_cur[3'd7 - obc_q[2:0]];
				end
				smsr_pkg::ACT_RISE: begin
					if (sel_q) begin
						sib_d = byte_in;
						ibc_d = ibc_n;
						if (rmode_q && cmd_q) begin
							obc_d = obc_n;
							if (obc_n >= 4'd8) begin
								load_en   = 1'b1;
								load_addr = ptr_q;
								ptr_d     = ptr_q + 8'd1;
								obc_d     = 4'd0;
							end
						end
						if (ibc_n >= 4'd8) begin
							if (!cmd_q) begin
								cmd_d   = 1'b1;
								rmode_d = byte_in[7];
								ptr_d   = {1'b0, byte_in[6:0]};
								if (byte_in[7]) begin
									load_en   = 1'b1;
									load_addr = {1'b0, byte_in[6:0]};
									ptr_d     = {1'b0, byte_in[6:0]} + 8'd1;
									obc_d     = 4'd0;
								end
							end else if (!rmode_q) begin
								if (ptr_q == smsr_pkg::ADDR_POWER && byte_in[7]) begin
									wr.clr = 1'b1;
								end else if (in_range(ptr_q)) begin
									wr.we   = 1'b1;
									wr.idx  = ptr_q[smsr_pkg::ADDR_W-1:0];
									wr.data = byte_in;
								end
								ptr_d = ptr_q + 8'd1;
							end
							sib_d = 8'h00;
							ibc_d = 4'd0;
						end
					end
				end
				default: begin
				end
			endcase
		end
		load_res = load_value(load_addr, samp);
		if (load_en) begin
			if (load_res[8]) pend_d = 1'b1;
			else             so_d   = load_res[7:0];
		end
	end

	assign rd_idx = load_addr[smsr_pkg::ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mval_q  <= 1'b0;
			sel_q   <= 1'b0;
			cmd_q   <= 1'b0;
			rmode_q <= 1'b0;
			sdo_q   <= 1'b1;
			pend_q  <= 1'b0;
			ptr_q   <= 8'h00;
			sib_q   <= 8'h00;
			so_q    <= 8'hFF;
			ibc_q   <= 4'd0;
			obc_q   <= 4'd0;
		end else begin
			if (beat_ready) mval_q <= beat_valid;
			sel_q   <= sel_d;
			cmd_q   <= cmd_d;
			rmode_q <= rmode_d;
			sdo_q   <= sdo_d;
			pend_q  <= pend_d;
			ptr_q   <= ptr_d;
			sib_q   <= sib_d;
			so_q    <= so_d;
			ibc_q   <= ibc_d;
			obc_q   <= obc_d;
		end
	end

	assign m_tvalid = mval_q;
	assign m_tdata  = {6'b000000, sel_q, sdo_q};

endmodule

/* hw/rtl/spi_motion_sensor_registers.sv */
// Top level of the SPI motion sensor register block.
//
//  channel | dir | beat contents
//  s_      | in  | tuser: action; tdata: cs_level, sdi_bit, accel x/y/z, rate x/y/z, temp_centi
//  m_      | out | tdata: sdo_level, is_selected
//
// One beat per cycle while the result is not stalled; each beat passes through all stages below.
// Stages: input register, sensor products, rounded samples, SPI state with result register.
// Store reads complete in the cycle after the byte is loaded, before any later beat needs it.
// arst_n clears all control state; the store reads as its reset image until written.
// A stalled result holds; upstream stages keep filling until all are occupied.
module spi_motion_sensor_registers (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// cs_level, sdi_bit, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, temp_centi
	input  logic [smsr_pkg::S_TDATA_W-1:0] s_tdata,
	// action
	input  logic [smsr_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// sdo_level, is_selected, zero padding
	output logic [smsr_pkg::M_TDATA_W-1:0] m_tdata
);

	smsr_pkg::pin_t        in_pin, pin_s3;
	smsr_pkg::sensor_t     in_sens;
	smsr_pkg::sample_set_t samp_s3;
	smsr_pkg::fs_t         fs;
	smsr_pkg::store_wr_t   wr;
	smsr_pkg::store_idx_t  rd_idx;
	logic [7:0]            rd_data;
	logic                  v_s3, ready_s3;

	assign in_pin.action       = s_tuser[1:0];
	assign in_pin.cs_level     = s_tdata[0];
	assign in_pin.sdi_bit      = s_tdata[1];
	assign in_sens.accel_x     = s_tdata[22:2];
	assign in_sens.accel_y     = s_tdata[43:23];
	assign in_sens.accel_z     = s_tdata[64:44];
	assign in_sens.rate_x      = s_tdata[85:65];
	assign in_sens.rate_y      = s_tdata[106:86];
	assign in_sens.rate_z      = s_tdata[127:107];
	assign in_sens.temp_centi  = s_tdata[143:128];

	smsr_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_pin    (in_pin),
		.in_sens   (in_sens),
		.fs        (fs),
		.out_valid (v_s3),
		.out_ready (ready_s3),
		.out_pin   (pin_s3),
		.out_samp  (samp_s3)
	);

	smsr_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_idx  (rd_idx),
		.rd_data (rd_data),
		.fs      (fs)
	);

	smsr_spi u_spi (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat_valid (v_s3),
		.beat_ready (ready_s3),
		.pin        (pin_s3),
		.samp       (samp_s3),
		.rd_data    (rd_data),
		.rd_idx     (rd_idx),
		.wr         (wr),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

/* hw/rtl/smsr_checker.sv */
// Port-level checks of the SPI motion sensor register block and their bind.
`include "spi_motion_sensor_registers_defines.svh"

module smsr_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [smsr_pkg::S_TDATA_W-1:0] s_tdata,
	input logic [smsr_pkg::S_TUSER_W-1:0] s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [smsr_pkg::M_TDATA_W-1:0] m_tdata
);

	`SMSR_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")
	`SMSR_ASSERT_IMPLY(a_in_open, clk, arst_n, !m_tvalid, s_tready, "input stalled with result slot empty")
	`SMSR_ASSERT_IMPLY(a_idle_sdo, clk, arst_n, m_tvalid && !m_tdata[1], m_tdata[0], "sdo low while deselected")
	`SMSR_ASSERT_IMPLY(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[7:2] == 6'b000000, "result padding not zero")

endmodule

bind spi_motion_sensor_registers smsr_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
